[rtl/sfpc_pkg.sv]
`timescale 1ns / 1ps

package sfpc_pkg;

  // Fixed bytes of the nine-byte frame.
  localparam logic [7:0] HDR_BYTE  = 8'hFF;
  localparam logic [7:0] FIX1_BYTE = 8'h17;
  localparam logic [7:0] FIX2_BYTE = 8'h04;
  localparam logic [7:0] FIX3_BYTE = 8'h00;
  localparam logic [7:0] FIX6_BYTE = 8'h13;
  localparam logic [7:0] FIX7_BYTE = 8'h88;

  // Byte positions inside the frame.
  localparam logic [3:0] POS_DATA_HIGH = 4'd4;
  localparam logic [3:0] POS_DATA_END  = 4'd6;

  // One received beat: a data byte or an idle-gap event.
  typedef struct packed {
    logic       is_gap;
    logic [7:0] data_byte;
  } sfpc_in_t;

  // One parsed frame.
  typedef struct packed {
    logic [15:0] concentration;
    logic        frame_ok;
  } sfpc_out_t;

endpackage

[rtl/sensor_frame_parser_checksum.sv]
`timescale 1ns / 1ps
// A frame result appears on the output in the cycle after its checksum beat is accepted.
// Throughput: one input beat per cycle; the parse state updates in the accepting cycle.
// Input is stalled only while a finished result is held and the output side does not take it.
// Reset (rst, synchronous, active high) returns the parser to hunting for the header byte,
// clears the running sum, byte count and stored data bytes, and empties the result register.
module sensor_frame_parser_checksum
  import sfpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  sfpc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output sfpc_out_t out_data
);

  typedef enum logic [7:0] {
    PH_HEAD = 8'b0000_0001,
    PH_B1   = 8'b0000_0010,
    PH_B2   = 8'b0000_0100,
    PH_B3   = 8'b0000_1000,
    PH_DATA = 8'b0001_0000,
    PH_B6   = 8'b0010_0000,
    PH_B7   = 8'b0100_0000,
    PH_CS   = 8'b1000_0000
  } phase_t;

  phase_t     phase, phase_next;
  logic [3:0] byte_position, byte_position_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] value_high, value_high_next;
  logic [7:0] value_low, value_low_next;
  logic       emit;
  logic       in_fire;
  logic [7:0] b;
  logic [3:0] pos_inc;
  logic [7:0] sum_inc;
  logic [7:0] expect_cs;

  // The result register frees up in the same cycle it is drained.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign b         = in_data.data_byte;
  assign pos_inc   = byte_position + 4'd1;
  assign sum_inc   = running_sum + b;
  assign expect_cs = (~running_sum) + 8'd1;

  // Next parse state for the current beat.
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    value_high_next    = value_high;
    value_low_next     = value_low;
    emit               = 1'b0;
    if (in_data.is_gap) begin
      phase_next         = PH_HEAD;
      byte_position_next = 4'd0;
      running_sum_next   = 8'd0;
      value_high_next    = 8'd0;
      value_low_next     = 8'd0;
    end else begin
      // A mismatched fixed byte drops the frame; a match advances to the next phase.
      unique case (phase)
        PH_HEAD: begin
          byte_position_next = 4'd0;
          running_sum_next   = 8'd0;
          if (b == HDR_BYTE) begin
            byte_position_next = 4'd1;
            phase_next         = PH_B1;
          end
        end
        PH_B1, PH_B2, PH_B3, PH_B6, PH_B7: begin
          logic [7:0] want;
          phase_t     adv;
          want = FIX1_BYTE;
          adv  = PH_B2;
          case (phase)
            PH_B2: begin
              want = FIX2_BYTE;
              adv  = PH_B3;
            end
            PH_B3: begin
              want = FIX3_BYTE;
              adv  = PH_DATA;
            end
            PH_B6: begin
              want = FIX6_BYTE;
              adv  = PH_B7;
            end
            PH_B7: begin
              want = FIX7_BYTE;
              adv  = PH_CS;
            end
            default: begin
              want = FIX1_BYTE;
              adv  = PH_B2;
            end
          endcase
          if (b == want) begin
            running_sum_next   = sum_inc;
            byte_position_next = pos_inc;
            phase_next         = adv;
          end else begin
            running_sum_next   = 8'd0;
            byte_position_next = 4'd0;
            phase_next         = PH_HEAD;
          end
        end
        PH_DATA: begin
          if (byte_position == POS_DATA_HIGH) begin
            value_high_next = b;
          end else begin
            value_low_next = b;
          end
          running_sum_next   = sum_inc;
          byte_position_next = pos_inc;
          if (pos_inc >= POS_DATA_END) begin
            phase_next = PH_B6;
          end
        end
        PH_CS: begin
          emit               = 1'b1;
          running_sum_next   = 8'd0;
          byte_position_next = 4'd0;
          phase_next         = PH_HEAD;
        end
        default: begin
          running_sum_next   = 8'd0;
          byte_position_next = 4'd0;
          phase_next         = PH_HEAD;
        end
      endcase
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEAD;
      byte_position <= 4'd0;
      running_sum   <= 8'd0;
      value_high    <= 8'd0;
      value_low     <= 8'd0;
    end else if (in_fire) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      value_high    <= value_high_next;
      value_low     <= value_low_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_data.concentration <= {value_high, value_low};
      out_data.frame_ok      <= (b == expect_cs);
    end
  end

  // A checksum beat always yields a result on the next cycle.
  a_cs_emits: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !in_data.is_gap && phase == PH_CS) |=> out_valid)
    else $error("checksum beat produced no result");

  // Input is held off only while a result waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result register");

  // The byte count tracks the frame phase.
  a_pos_head: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HEAD) |-> (byte_position == 4'd0 && running_sum == 8'd0))
    else $error("hunting with stale count or sum");

  a_pos_data: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (byte_position == 4'd4 || byte_position == 4'd5))
    else $error("data phase at wrong byte position");

  // An idle gap clears the parser.
  a_gap_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.is_gap) |=> (phase == PH_HEAD && value_high == 8'd0
      && value_low == 8'd0))
    else $error("idle gap did not reset parser");

endmodule
